// ----- rtl/spi_pkg.sv -----
package spi_pkg;

    localparam int unsigned FracBitsDefault = 16;
    localparam int unsigned TBits = 30;
    localparam int unsigned CoordW = 32;
    localparam int unsigned DiffW = 33;
    localparam int unsigned ProdW = 66;
    localparam int unsigned DotW = 68;
    localparam int unsigned MagW = 67;
    localparam int unsigned ThrW = 32;

    // Threshold reset is round(1e-5 * 2^(2*frac)).
    function automatic logic [ThrW-1:0] thr_reset(input int unsigned frac);
        logic [63:0] v;
        begin
            v = ((64'd1 << (2 * frac)) + 64'd50000) / 64'd100000;
            return v[ThrW-1:0];
        end
    endfunction

endpackage

// ----- rtl/spi_if.sv -----
interface spi_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [spi_pkg::CoordW-1:0]    start_x, start_y, start_z;
    logic signed [spi_pkg::CoordW-1:0]    end_x, end_y, end_z;
    logic signed [spi_pkg::CoordW-1:0]    plane_point_x, plane_point_y, plane_point_z;
    logic signed [spi_pkg::CoordW-1:0]    normal_x, normal_y, normal_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    plane_point_x, plane_point_y, plane_point_z,
                    normal_x, normal_y, normal_z, input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  plane_point_x, plane_point_y, plane_point_z,
                  normal_x, normal_y, normal_z, output ready);
endinterface

interface spi_out_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic signed [spi_pkg::CoordW-1:0] cross_x, cross_y, cross_z;

    modport source (output valid, hit, cross_x, cross_y, cross_z, input ready);
    modport sink (input valid, hit, cross_x, cross_y, cross_z, output ready);
endinterface

// ----- rtl/spi_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, TBits stages.
// Computes floor(num * 2^TBits / den) for num < den.
module spi_divider (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [spi_pkg::MagW-1:0]      i_num,
    input  logic [spi_pkg::MagW-1:0]      i_den,
    output logic [spi_pkg::TBits-1:0]     o_quo
);
    localparam int unsigned N = spi_pkg::TBits;
    localparam int unsigned W = spi_pkg::MagW;

    logic [W-1:0] r_rem [N+1];
    logic [W-1:0] r_den [N+1];
    logic [N-1:0] r_quo [N+1];

    always_comb begin
        r_rem[0] = i_num;
        r_den[0] = i_den;
        r_quo[0] = '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [W:0]   n_sh;
        logic [W:0]   n_diff;
        always_comb begin
            n_sh   = {r_rem[k], 1'b0};
            n_diff = n_sh - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k+1] <= r_den[k];
                if (!n_diff[W]) begin
                    r_rem[k+1] <= n_diff[W-1:0];
                    r_quo[k+1] <= {r_quo[k][N-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_sh[W-1:0];
                    r_quo[k+1] <= {r_quo[k][N-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[N];
endmodule

// ----- rtl/segment_plane_intersection.sv -----
// Segment / plane intersection, fully pipelined.
// Throughput one item per cycle while the output is not stalled.
// Depth is set by the 30-stage quotient pipeline that forms t.
// Backpressure stalls the whole pipeline in place; s_in.ready is high whenever the
// output register is empty or being taken. Synchronous active-low reset clears valids
// and loads the parallel threshold with its default.
module segment_plane_intersection #(
    parameter int unsigned FRACTION_BITS = spi_pkg::FracBitsDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [spi_pkg::ThrW-1:0]  i_cfg_wdata,
    spi_in_if.sink                    s_in,
    spi_out_if.source                 m_out
);
    localparam int unsigned CW = spi_pkg::CoordW;
    localparam int unsigned DW = spi_pkg::DiffW;
    localparam int unsigned PW = spi_pkg::ProdW;
    localparam int unsigned SW = spi_pkg::DotW;
    localparam int unsigned MW = spi_pkg::MagW;
    localparam int unsigned TB = spi_pkg::TBits;
    localparam int unsigned DivLat = TB;
    localparam int unsigned Lat = DivLat + 6;

    logic en;
    logic [Lat-1:0] r_vld;
    logic [spi_pkg::ThrW-1:0] r_thr;

    assign en = !r_vld[Lat-1] || m_out.ready;
    assign s_in.ready = en;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= spi_pkg::thr_reset(FRACTION_BITS);
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], s_in.valid};
        end
    end

    // Stage 1: differences.
    logic signed [DW-1:0] r1_d [3], r1_l [3];
    logic signed [CW-1:0] r1_n [3], r1_s [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_s[0] <= s_in.start_x; r1_s[1] <= s_in.start_y; r1_s[2] <= s_in.start_z;
            r1_n[0] <= s_in.normal_x; r1_n[1] <= s_in.normal_y; r1_n[2] <= s_in.normal_z;
            r1_d[0] <= DW'(s_in.end_x) - DW'(s_in.start_x);
            r1_d[1] <= DW'(s_in.end_y) - DW'(s_in.start_y);
            r1_d[2] <= DW'(s_in.end_z) - DW'(s_in.start_z);
            r1_l[0] <= DW'(s_in.plane_point_x) - DW'(s_in.start_x);
            r1_l[1] <= DW'(s_in.plane_point_y) - DW'(s_in.start_y);
            r1_l[2] <= DW'(s_in.plane_point_z) - DW'(s_in.start_z);
        end
    end

    // Stage 2: six 33x32 products.
    logic signed [PW-1:0] r2_pd [3], r2_pl [3];
    logic signed [DW-1:0] r2_d [3];
    logic signed [CW-1:0] r2_s [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r2_pd[k] <= PW'(r1_d[k]) * PW'(r1_n[k]);
                r2_pl[k] <= PW'(r1_l[k]) * PW'(r1_n[k]);
            end
            r2_d <= r1_d;
            r2_s <= r1_s;
        end
    end

    // Stage 3: dot product sums.
    logic signed [SW-1:0] r3_den, r3_num;
    logic signed [DW-1:0] r3_d [3];
    logic signed [CW-1:0] r3_s [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_den <= SW'(r2_pd[0]) + SW'(r2_pd[1]) + SW'(r2_pd[2]);
            r3_num <= SW'(r2_pl[0]) + SW'(r2_pl[1]) + SW'(r2_pl[2]);
            r3_d <= r2_d;
            r3_s <= r2_s;
        end
    end

    // Stage 4: magnitudes and hit decision.
    logic [MW-1:0] n4_aden, n4_anum;
    logic          n4_hit, n4_one;
    always_comb begin
        n4_aden = r3_den[SW-1] ? MW'(-r3_den) : MW'(r3_den);
        n4_anum = r3_num[SW-1] ? MW'(-r3_num) : MW'(r3_num);
        n4_hit  = 1'b1;
        if (n4_aden == '0 || n4_aden < MW'(r_thr)) n4_hit = 1'b0;
        if (n4_anum != '0 && (r3_num[SW-1] != r3_den[SW-1])) n4_hit = 1'b0;
        if (n4_anum > n4_aden) n4_hit = 1'b0;
        n4_one = (n4_anum == n4_aden);
    end

    logic [MW-1:0] r4_aden, r4_anum;
    logic          r4_hit, r4_one;
    logic signed [DW-1:0] r4_d [3];
    logic signed [CW-1:0] r4_s [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_aden <= n4_aden;
            r4_anum <= n4_one ? '0 : n4_anum;
            r4_hit  <= n4_hit;
            r4_one  <= n4_one;
            r4_d <= r3_d;
            r4_s <= r3_s;
        end
    end

    // Quotient pipeline for t.
    logic [TB-1:0] div_q;
    spi_divider u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_anum),
        .i_den (r4_aden),
        .o_quo (div_q)
    );

    // Side pipeline for data skipping the divider.
    logic          r_sh_hit [DivLat], r_sh_one [DivLat];
    logic signed [DW-1:0] r_sh_d [DivLat][3];
    logic signed [CW-1:0] r_sh_s [DivLat][3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sh_hit[0] <= r4_hit; r_sh_one[0] <= r4_one;
            r_sh_d[0] <= r4_d; r_sh_s[0] <= r4_s;
            for (int k = 1; k < DivLat; k++) begin
                r_sh_hit[k] <= r_sh_hit[k-1]; r_sh_one[k] <= r_sh_one[k-1];
                r_sh_d[k] <= r_sh_d[k-1]; r_sh_s[k] <= r_sh_s[k-1];
            end
        end
    end

    // Stage 5: offset product |d| * t.
    localparam int unsigned TW = TB + 1;
    localparam int unsigned OW = DW + TW;
    logic [TW-1:0] n5_t;
    logic [OW-1:0] r5_off [3];
    logic          r5_hit;
    logic [2:0]    r5_sgn;
    logic signed [CW-1:0] r5_s [3];
    always_comb begin
        n5_t = r_sh_one[DivLat-1] ? TW'(1) << TB : TW'(div_q);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r5_off[k] <= OW'(r_sh_d[DivLat-1][k][DW-1] ? -r_sh_d[DivLat-1][k]
                                                           : r_sh_d[DivLat-1][k]) * OW'(n5_t);
                r5_sgn[k] <= r_sh_d[DivLat-1][k][DW-1];
            end
            r5_hit <= r_sh_hit[DivLat-1];
            r5_s   <= r_sh_s[DivLat-1];
        end
    end

    // Stage 6: round, add to start, saturate; a miss gives zero.
    localparam int unsigned RW = OW - TB;
    localparam int unsigned PtW = RW + 2;
    logic signed [CW-1:0] n6_p [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [OW-1:0]         rnd;
            logic signed [PtW-1:0] p;
            rnd = r5_off[k] + (OW'(1) << (TB - 1));
            if (r5_sgn[k])
                p = PtW'(r5_s[k]) - PtW'(rnd[OW-1:TB]);
            else
                p = PtW'(r5_s[k]) + PtW'(rnd[OW-1:TB]);
            if (!r5_hit)
                n6_p[k] = '0;
            else if (p > PtW'(32'sh7fffffff))
                n6_p[k] = 32'sh7fffffff;
            else if (p < -PtW'(64'sh80000000))
                n6_p[k] = 32'sh80000000;
            else
                n6_p[k] = p[CW-1:0];
        end
    end

    logic r6_hit;
    logic signed [CW-1:0] r6_p [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_hit <= r5_hit;
            r6_p   <= n6_p;
        end
    end

    assign m_out.valid   = r_vld[Lat-1];
    assign m_out.hit     = r6_hit;
    assign m_out.cross_x = r6_p[0];
    assign m_out.cross_y = r6_p[1];
    assign m_out.cross_z = r6_p[2];
endmodule

// ----- verif/segment_plane_intersection_tb.sv -----
`timescale 1ns / 100ps

module segment_plane_intersection_tb;

    localparam int unsigned ClkHalf = 5;
    localparam logic [spi_pkg::ThrW-1:0] DefaultThreshold = 32'd42950;
    localparam int unsigned PipeDrain = 45;
    localparam int unsigned StallLimit = 5000;
    localparam int unsigned HoldOffCycles = 300;
    localparam int One = 65536;

    typedef logic signed [spi_pkg::CoordW-1:0] t_coord;

    typedef struct {
        logic   hit;
        t_coord x;
        t_coord y;
        t_coord z;
    } t_crossing;

    // One geometry query (start xyz, end xyz, plane point xyz, normal xyz), its threshold and expected crossing.
    typedef struct {
        t_coord                   c [12];
        logic [spi_pkg::ThrW-1:0] thr;
        logic                     known;
        t_crossing                res;
    } t_query_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [spi_pkg::ThrW-1:0] i_cfg_wdata;

    spi_in_if  in_bus ();
    spi_out_if out_bus ();

    segment_plane_intersection DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_in        (in_bus),
        .m_out       (out_bus)
    );

    logic [spi_pkg::ThrW-1:0] threshold;
    t_crossing       crossing_q [$];
    t_crossing       staged_crossing;
    int unsigned     error_count;
    int unsigned     stall_cycles;
    logic            quiet;
    logic            hold_off;
    t_query_row      rows [$];

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #ClkHalf i_clk = 1'b1;
        #ClkHalf i_clk = 1'b0;
    end

    // Expected intersection of one segment with one plane, at the current threshold.
    function automatic t_crossing predict_crossing(input t_coord c [12]);
        logic signed [127:0] s [3];
        logic signed [127:0] d [3];
        logic signed [127:0] den, num, aden, anum, frac_t, off, p;
        t_crossing r;
        r = '{hit: 1'b0, x: '0, y: '0, z: '0};
        den = '0;
        num = '0;
        for (int i = 0; i < 3; i++) begin
            s[i] = c[i];
            d[i] = c[3 + i] - s[i];
            den += d[i] * c[9 + i];
            num += (c[6 + i] - s[i]) * c[9 + i];
        end
        aden = den < 0 ? -den : den;
        anum = num < 0 ? -num : num;
        if (aden == 0 || aden < {96'd0, threshold}) return r;
        if (num != 0 && ((num < 0) != (den < 0))) return r;
        if (anum > aden) return r;
        // The ratio is kept with 30 fractional bits, truncated.
        frac_t = (anum <<< spi_pkg::TBits) / aden;
        r.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            off = ((d[i] < 0 ? -d[i] : d[i]) * frac_t
                   + (128'sd1 <<< (spi_pkg::TBits - 1))) >>> spi_pkg::TBits;
            p = d[i] < 0 ? s[i] - off : s[i] + off;
            if (p > 128'sd2147483647) p = 128'sd2147483647;
            if (p < -128'sd2147483648) p = -128'sd2147483648;
            if (i == 0) r.x = p[31:0];
            else if (i == 1) r.y = p[31:0];
            else r.z = p[31:0];
        end
        return r;
    endfunction

    // Input monitor: every accepted transaction queues its expected crossing.
    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready) crossing_q.push_back(staged_crossing);
    end

    // Output checker against the oldest expected crossing.
    always @(posedge i_clk) begin
        t_crossing e;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (crossing_q.size() == 0) begin
                $error("result with no expected crossing: hit %0b", out_bus.hit);
                error_count++;
            end else begin
                e = crossing_q.pop_front();
                if (out_bus.hit !== e.hit) begin
                    $error("hit: expected %0b, actual %0b", e.hit, out_bus.hit);
                    error_count++;
                end
                if (out_bus.cross_x !== e.x) begin
                    $error("cross_x: expected %0d, actual %0d", e.x, out_bus.cross_x);
                    error_count++;
                end
                if (out_bus.cross_y !== e.y) begin
                    $error("cross_y: expected %0d, actual %0d", e.y, out_bus.cross_y);
                    error_count++;
                end
                if (out_bus.cross_z !== e.z) begin
                    $error("cross_z: expected %0d, actual %0d", e.z, out_bus.cross_z);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= StallLimit) begin
            $display("FAIL segment_plane_intersection");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result sink: random stall bursts, one long hold-off, and a steady tail.
    initial begin
        int n;
        out_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                repeat (HoldOffCycles) @(negedge i_clk) out_bus.ready <= 1'b0;
                hold_off = 1'b0;
            end else if (quiet) begin
                @(negedge i_clk) out_bus.ready <= 1'b1;
            end else begin
                n = $urandom_range(1, 15);
                if ($urandom_range(0, 2) == 0) begin
                    repeat (n) @(negedge i_clk) out_bus.ready <= 1'b0;
                end else begin
                    repeat (n) @(negedge i_clk) out_bus.ready <= 1'b1;
                end
            end
        end
    end

    // Register write, only with the pipeline empty.
    task automatic write_threshold(input logic [spi_pkg::ThrW-1:0] value);
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (crossing_q.size() != 0) @(posedge i_clk);
        repeat (PipeDrain) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        threshold = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offers one query and returns once it has been accepted.
    task automatic offer_query(input t_coord c [12], input t_crossing res);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 15)) @(negedge i_clk) in_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_bus.valid <= 1'b1;
        in_bus.start_x <= c[0];
        in_bus.start_y <= c[1];
        in_bus.start_z <= c[2];
        in_bus.end_x <= c[3];
        in_bus.end_y <= c[4];
        in_bus.end_z <= c[5];
        in_bus.plane_point_x <= c[6];
        in_bus.plane_point_y <= c[7];
        in_bus.plane_point_z <= c[8];
        in_bus.normal_x <= c[9];
        in_bus.normal_y <= c[10];
        in_bus.normal_z <= c[11];
        staged_crossing = res;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
    endtask

    function automatic t_coord pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Random query: mostly plane points drawn between start and end on each axis, plus noise and extremes.
    task automatic random_query();
        t_coord c [12];
        int mode;
        longint s, e, f;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            if (mode < 7) begin
                s = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
                e = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
                f = $urandom_range(0, One);
                c[i] = t_coord'(s);
                c[3 + i] = t_coord'(e);
                c[6 + i] = t_coord'(s + (((e - s) * f) >>> 16));
                if ($urandom_range(0, 3) == 0) c[6 + i] += int'($urandom_range(0, 512)) - 256;
                c[9 + i] = int'($urandom_range(0, 1 << 19)) - (1 << 18);
            end else if (mode < 9) begin
                c[i] = $urandom;
                c[3 + i] = $urandom;
                c[6 + i] = $urandom;
                c[9 + i] = $urandom;
            end else begin
                c[i] = pick_extreme();
                c[3 + i] = pick_extreme();
                c[6 + i] = pick_extreme();
                c[9 + i] = pick_extreme();
            end
        end
        offer_query(c, predict_crossing(c));
    endtask

    function automatic t_query_row row(input t_coord c [12],
                                       input logic [spi_pkg::ThrW-1:0] thr,
                                       input logic known, input logic hit,
                                       input t_coord x, input t_coord y, input t_coord z);
        t_query_row r;
        r.c = c;
        r.thr = thr;
        r.known = known;
        r.res = '{hit: hit, x: x, y: y, z: z};
        return r;
    endfunction

    // Directed table, then random phases at several thresholds.
    initial begin
        t_coord mn, mx;
        t_crossing res;
        mn = 32'sh8000_0000;
        mx = 32'sh7FFF_FFFF;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_bus.valid = 1'b0;
        {in_bus.start_x, in_bus.start_y, in_bus.start_z} = '0;
        {in_bus.end_x, in_bus.end_y, in_bus.end_z} = '0;
        {in_bus.plane_point_x, in_bus.plane_point_y, in_bus.plane_point_z} = '0;
        {in_bus.normal_x, in_bus.normal_y, in_bus.normal_z} = '0;
        threshold = DefaultThreshold;
        staged_crossing = '{hit: 1'b0, x: '0, y: '0, z: '0};
        error_count = 0;
        stall_cycles = 0;
        quiet = 1'b0;
        hold_off = 1'b0;

        // Zero denominator is a miss at any threshold.
        rows.push_back(row('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, DefaultThreshold, 1, 0, 0, 0, 0));
        // Plane z = 0 crossed halfway.
        rows.push_back(row('{0,0,-One, 0,0,One, 0,0,0, 0,0,One},
                           DefaultThreshold, 1, 1, 0, 0, 0));
        // Zero numerator gives the start point.
        rows.push_back(row('{0,0,-One, 0,0,One, 0,0,-One, 0,0,One},
                           DefaultThreshold, 1, 1, 0, 0, -One));
        // Plane through the end point.
        rows.push_back(row('{0,0,-One, 0,0,One, 0,0,One, 0,0,One},
                           DefaultThreshold, 1, 1, 0, 0, One));
        // Plane behind the start.
        rows.push_back(row('{0,0,-One, 0,0,One, 0,0,-2*One, 0,0,One},
                           DefaultThreshold, 1, 0, 0, 0, 0));
        // Plane beyond the end.
        rows.push_back(row('{0,0,-One, 0,0,One, 0,0,3*One, 0,0,One},
                           DefaultThreshold, 1, 0, 0, 0, 0));
        // Segment parallel to the plane.
        rows.push_back(row('{0,0,-One, 0,0,One, 0,0,0, One,0,0},
                           DefaultThreshold, 1, 0, 0, 0, 0));
        // Denominator of one LSB, below the default threshold.
        rows.push_back(row('{0,0,0, 0,0,1, 0,0,0, 0,0,1}, DefaultThreshold, 1, 0, 0, 0, 0));
        // Full-range coordinates.
        rows.push_back(row('{mn,mn,mn, mx,mx,mx, 0,0,0, 1,0,0}, DefaultThreshold, 0, 0, 0, 0, 0));
        rows.push_back(row('{mx,mx,mx, mn,mn,mn, 0,0,0, mn,mn,mn},
                           DefaultThreshold, 0, 0, 0, 0, 0));
        rows.push_back(row('{mn,mn,mn, mx,mx,mx, mx,mx,mx, mx,mx,mx},
                           DefaultThreshold, 0, 0, 0, 0, 0));
        rows.push_back(row('{mx,mn,mx, mn,mx,mn, 0,0,0, mx,mn,1},
                           DefaultThreshold, 0, 0, 0, 0, 0));
        // Negative normal, oblique segment.
        rows.push_back(row('{One,2*One,-One, 3*One,-4*One,One, 0,0,One/4, 0,0,-One},
                           DefaultThreshold, 0, 0, 0, 0, 0));
        // Threshold zero: a one-LSB denominator now counts, a zero one still misses.
        rows.push_back(row('{0,0,0, 0,0,1, 0,0,0, 0,0,1}, '0, 1, 1, 0, 0, 0));
        rows.push_back(row('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, '0, 1, 0, 0, 0, 0));
        // Largest threshold.
        rows.push_back(row('{0,0,-One, 0,0,One, 0,0,0, 0,0,One}, '1, 1, 1, 0, 0, 0));
        rows.push_back(row('{0,0,-One/2, 0,0,One/2, 0,0,0, 0,0,One-1}, '1, 1, 0, 0, 0, 0));
        rows.push_back(row('{0,0,-One/2, 0,0,One/2, 0,0,0, 0,0,One}, '1, 0, 0, 0, 0, 0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].thr != threshold) write_threshold(rows[k].thr);
            res = rows[k].known ? rows[k].res : predict_crossing(rows[k].c);
            offer_query(rows[k].c, res);
        end

        write_threshold(DefaultThreshold);
        for (int k = 0; k < 500; k++) begin
            if (k == 200) hold_off = 1'b1;
            random_query();
        end
        write_threshold('0);
        for (int k = 0; k < 400; k++) random_query();
        write_threshold('1);
        for (int k = 0; k < 400; k++) random_query();
        write_threshold($urandom_range(0, 1 << 24));
        for (int k = 0; k < 400; k++) begin
            if (k == 200) quiet = 1'b1;
            random_query();
        end
        @(negedge i_clk);
        in_bus.valid <= 1'b0;

        while (crossing_q.size() != 0) @(posedge i_clk);
        repeat (PipeDrain) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS segment_plane_intersection");
        end else begin
            $display("FAIL segment_plane_intersection");
        end
        $finish;
    end

endmodule

// ----- segment_plane_intersection.f -----
rtl/spi_pkg.sv
rtl/spi_if.sv
rtl/spi_divider.sv
rtl/segment_plane_intersection.sv
verif/segment_plane_intersection_tb.sv
